// File: src/iost_pkg.sv
// ----------------------------------------------------------------------------
// iost_pkg
// Shared types and codes for the insertion-ordered set table.
// ----------------------------------------------------------------------------
package iost_pkg;

   localparam int OP_W      = 3;
   localparam int VALUE_W   = 32;
   localparam int POS_W     = 6;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef logic [OP_W-1:0]        op_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]       pos_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [COUNT_W-1:0]     count_type;

   localparam op_type OP_ADD      = 3'd0;
   localparam op_type OP_REMOVE   = 3'd1;
   localparam op_type OP_CONTAINS = 3'd2;
   localparam op_type OP_CLEAR    = 3'd3;
   localparam op_type OP_READ     = 3'd4;

   localparam status_type ST_DONE     = 2'd0;
   localparam status_type ST_NOEFFECT = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_RANGE    = 2'd3;

   typedef struct packed {
      logic       load;
      logic       scan;
      logic       rd_pos;
      logic       shift_wr;
      logic       append;
      logic       dec;
      logic       clr;
      logic       finish;
      logic       take_data;
      status_type res_status;
      logic       res_member;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   pos_ok;
      logic   hit;
      logic   last;
   } sts_type;

endpackage

// File: src/iost_ram.sv
// ----------------------------------------------------------------------------
// iost_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iost_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/iost_dp.sv
// ----------------------------------------------------------------------------
// iost_dp
// Datapath: request registers, member count, entry store, scan pointers and
// the result register.
// ----------------------------------------------------------------------------
module iost_dp
   import iost_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   op_type       op_ff, op_in;
   value_type    value_ff, value_in;
   pos_type      pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   logic          pend_valid_ff, pend_valid_in;
   status_type    res_status_ff, res_status_in;
   logic          res_member_ff, res_member_in;
   value_type     res_value_ff, res_value_in;
   count_type     res_count_ff, res_count_in;

   logic          scan_issue;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   value_type     rd_data;
   logic [CW-1:0] count_m1;

   assign count_m1   = count_ff - 1'b1;
   assign scan_issue = cmd.scan && (scan_idx_ff < count_ff);

   always_comb begin
      op_in         = cmd.load ? req_tuser : op_ff;
      value_in      = cmd.load ? value_type'(req_tdata[VALUE_W-1:0]) : value_ff;
      pos_in        = cmd.load ? req_tdata[VALUE_W+POS_W-1:VALUE_W] : pos_ff;
      scan_idx_in   = scan_idx_ff;
      pend_idx_in   = pend_idx_ff;
      pend_valid_in = scan_issue;
      if (cmd.load) begin
         scan_idx_in = '0;
      end else if (scan_issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         pend_idx_in = scan_idx_ff;
      end
      count_in = count_ff;
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.dec) begin
         count_in = count_m1;
      end
   end

   // store ports: appends and shift writes never share a cycle
   always_comb begin
      wr_en   = cmd.append || (cmd.shift_wr && pend_valid_ff);
      wr_addr = cmd.append ? AW'(count_ff) : AW'(pend_idx_ff - 1'b1);
      wr_data = cmd.append ? value_ff : rd_data;
      rd_en   = scan_issue || cmd.rd_pos;
      rd_addr = cmd.rd_pos ? AW'(pos_ff) : AW'(scan_idx_ff);
   end

   iost_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.op     = op_ff;
      sts.empty  = (count_ff == '0);
      sts.full   = (count_ff == CW'(CAPACITY));
      sts.pos_ok = (CMPW'(pos_ff) < CMPW'(count_ff));
      sts.hit    = pend_valid_ff && (rd_data == value_ff);
      sts.last   = pend_valid_ff && (pend_idx_ff == count_m1);
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_member_in = res_member_ff;
      res_value_in  = res_value_ff;
      res_count_in  = res_count_ff;
      if (cmd.finish) begin
         res_status_in = cmd.res_status;
         res_member_in = cmd.res_member;
         res_value_in  = cmd.take_data ? rd_data : '0;
         res_count_in  = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_member_ff <= res_member_in;
      res_value_ff  <= res_value_in;
      res_count_ff  <= res_count_in;
   end

   assign rsp_tdata = {res_count_ff, res_value_ff, res_member_ff};
   assign rsp_tuser = res_status_ff;

endmodule

// File: src/iost_ctrl.sv
// ----------------------------------------------------------------------------
// iost_ctrl
// Controller: sequences decode, scan, shift and result hand-off.
// ----------------------------------------------------------------------------
module iost_ctrl
   import iost_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   status_type st_ff, st_in;
   logic       member_ff, member_in;
   logic       take_ff, take_in;
   logic       rsp_valid_ff, rsp_valid_in;

   status_type miss_st;
   logic       miss_append;

   // outcome when the value is not a member
   always_comb begin
      miss_st     = ST_NOEFFECT;
      miss_append = 1'b0;
      case (sts.op)
         OP_ADD: begin
            if (sts.full) begin
               miss_st = ST_FULL;
            end else begin
               miss_st     = ST_DONE;
               miss_append = 1'b1;
            end
         end
         OP_CONTAINS: begin
            miss_st = ST_DONE;
         end
         default: begin
            miss_st = ST_NOEFFECT;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      st_in     = st_ff;
      member_in = member_ff;
      take_in   = take_ff;
      cmd       = '0;
      cmd.res_status = st_ff;
      cmd.res_member = member_ff;
      cmd.take_data  = take_ff;
      req_tready     = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            member_in = 1'b0;
            take_in   = 1'b0;
            state_in  = S_DONE;
            case (sts.op)
               OP_ADD, OP_REMOVE, OP_CONTAINS: begin
                  if (sts.empty) begin
                     st_in      = miss_st;
                     cmd.append = miss_append;
                  end else begin
                     cmd.scan = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               OP_CLEAR: begin
                  cmd.clr = 1'b1;
                  st_in   = ST_DONE;
               end
               OP_READ: begin
                  if (sts.pos_ok) begin
                     cmd.rd_pos = 1'b1;
                     take_in    = 1'b1;
                     st_in      = ST_DONE;
                  end else begin
                     st_in = ST_RANGE;
                  end
               end
               default: begin
                  st_in = ST_NOEFFECT;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               member_in = 1'b1;
               state_in  = S_DONE;
               case (sts.op)
                  OP_ADD: begin
                     st_in = ST_NOEFFECT;
                  end
                  OP_REMOVE: begin
                     st_in = ST_DONE;
                     if (sts.last) begin
                        cmd.dec = 1'b1;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     st_in = ST_DONE;
                  end
               endcase
            end else if (sts.last) begin
               st_in      = miss_st;
               cmd.append = miss_append;
               state_in   = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.scan     = 1'b1;
            cmd.shift_wr = 1'b1;
            if (sts.last) begin
               cmd.dec  = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      st_ff     <= st_in;
      member_ff <= member_in;
      take_ff   <= take_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: src/insertion_ordered_set_table.sv
// ----------------------------------------------------------------------------
// insertion_ordered_set_table
// Fixed-capacity set of distinct 32-bit integers kept packed in insertion
// order, with add, remove, contains, clear and read-entry operations.
//
//   channel   direction  tuser          tdata
//   req_*     in         operation      value, position
//   rsp_*     out        status         member, value_out, count
//
// Add, remove and contains scan the store one entry per cycle through its
// single read port, remove shifting later entries down during the same pass.
// Clear, read entry and other codes need no scan. One item is worked on at a
// time; the next is taken while the previous result waits in the output
// register. Reset clears the count, not the store, and needs no clearing pass.
// ----------------------------------------------------------------------------
module insertion_ordered_set_table
   import iost_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], position[37:32]
   input  logic [OP_W-1:0]        req_tuser,  // operation[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // member[0], value_out[32:1], count[39:33]
   output logic [STATUS_W-1:0]    rsp_tuser   // status[1:0]
);

   cmd_type cmd;
   sts_type sts;

   iost_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iost_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in progress");

   a_full_not_member : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_FULL)) |-> !rsp_tdata[0])
      else $error("full status reported for a member");

   a_data_only_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[VALUE_W:1] != '0)) |-> (rsp_tuser == ST_DONE))
      else $error("entry data returned without done status");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((CAPACITY > 127) ||
         (rsp_tdata[RSP_TDATA_W-1:VALUE_W+1] <= COUNT_W'(CAPACITY))))
      else $error("count beyond capacity");

endmodule
